@@ rtl/core/frs_pkg.sv @@
// frs_pkg: shared types, codes and ring geometry for the frame ring store.
// Standalone; imported by frs_ctrl, the top level and the checker.
package frs_pkg;

  localparam int RING_SLOTS      = 8;
  localparam int MAX_FRAME_BYTES = 1518;

  localparam int DATA_W      = 8;
  localparam int LEN_W       = 11;
  localparam int IDX_W       = 3;
  localparam int OFF_W       = 11;
  localparam int COUNT_OUT_W = 4;
  localparam int STATUS_W    = 2;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    status_t                  status;
    logic [DATA_W-1:0]        read_byte;
    logic [LEN_W-1:0]         stored_length;
    logic [COUNT_OUT_W-1:0]   frame_count;
    logic                     frame_done;
    logic                     echo_valid;
    logic [DATA_W-1:0]        echo_byte;
  } rsp_t;

endpackage

@@ rtl/core/frs_ram.sv @@
// frs_ram: single-port synchronous RAM, registered read.
// No dependencies.
module frs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // rdata holds between reads
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/core/frs_ctrl.sv @@
// frs_ctrl: transaction sequencer, ring pointers and the two RAMs.
// Depends on frs_pkg and frs_ram.
module frs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        command,
  input  logic [frs_pkg::DATA_W-1:0]  data_byte,
  input  logic [frs_pkg::LEN_W-1:0]   frame_length,
  input  logic [frs_pkg::IDX_W-1:0]   frame_index,
  input  logic [frs_pkg::OFF_W-1:0]   byte_offset,
  input  logic                        loopback,
  output logic                        res_valid,
  input  logic                        res_ready,
  output frs_pkg::rsp_t               res_out
);
  import frs_pkg::*;

  localparam int SLOT_W = $clog2(RING_SLOTS);
  localparam int CNT_W  = $clog2(RING_SLOTS + 1);
  localparam int WOFF_W = $clog2(MAX_FRAME_BYTES);
  localparam int DEPTH  = RING_SLOTS * MAX_FRAME_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = ((WOFF_W > LEN_W) ? WOFF_W : LEN_W) + 1;
  localparam int SUM_W  = ((SLOT_W > IDX_W) ? SLOT_W : IDX_W) + 2;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_EXEC    = 4'b0010,
    ST_LEN_CHK = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   head;
  logic [ADDR_W-1:0]   head_base;
  logic [CNT_W-1:0]    held;
  logic [WOFF_W-1:0]   woff;

  logic                it_cmd;
  logic [DATA_W-1:0]   it_data;
  logic [LEN_W-1:0]    it_len;
  logic [IDX_W-1:0]    it_idx;
  logic [OFF_W-1:0]    it_off;
  logic [SLOT_W-1:0]   slot_reg;
  rsp_t                res;
  rsp_t                res_exec;
  logic                use_mem;

  logic                len_bad;
  logic                commit;
  logic [CNT_W-1:0]    held_adj;
  logic [CNT_W-1:0]    held_store;
  logic [SUM_W-1:0]    slot_sum;
  logic [SLOT_W-1:0]   slot_rd;
  logic                idx_bad;
  logic                off_bad;
  logic                head_wrap;
  logic [ADDR_W-1:0]   rd_addr;

  logic                byte_en, byte_we;
  logic [ADDR_W-1:0]   byte_addr;
  logic [DATA_W-1:0]   byte_rdata;
  logic                len_en, len_we;
  logic [SLOT_W-1:0]   len_addr;
  logic [LEN_W-1:0]    len_rdata;

  always_comb begin
    len_bad  = (it_len == '0) || (CMP_W'(it_len) > CMP_W'(MAX_FRAME_BYTES));
    commit   = (CMP_W'(woff) + CMP_W'(1)) >= CMP_W'(it_len);
    // full ring: the oldest frame goes as a new frame's first byte lands
    held_adj = ((woff == '0) && (held >= CNT_W'(RING_SLOTS))) ?
               CNT_W'(RING_SLOTS - 1) : held;
    held_store = commit ? held_adj + CNT_W'(1) : held_adj;
    head_wrap  = (head == SLOT_W'(RING_SLOTS - 1));

    idx_bad  = SUM_W'(it_idx) >= SUM_W'(held);
    slot_sum = SUM_W'(head) + SUM_W'(RING_SLOTS) - SUM_W'(held) + SUM_W'(it_idx);
    slot_rd  = (slot_sum >= SUM_W'(RING_SLOTS)) ?
               SLOT_W'(slot_sum - SUM_W'(RING_SLOTS)) : SLOT_W'(slot_sum);

    off_bad  = (CMP_W'(it_off) >= CMP_W'(len_rdata)) ||
               (CMP_W'(it_off) >= CMP_W'(MAX_FRAME_BYTES));
    rd_addr  = ADDR_W'(ADDR_W'(slot_reg) * ADDR_W'(MAX_FRAME_BYTES)) + ADDR_W'(it_off);

    byte_en   = ((state == ST_EXEC) && (it_cmd == CMD_STORE) && !len_bad) ||
                ((state == ST_LEN_CHK) && !off_bad);
    byte_we   = (state == ST_EXEC);
    byte_addr = (state == ST_EXEC) ? head_base + ADDR_W'(woff) : rd_addr;

    len_en   = (state == ST_EXEC) &&
               (((it_cmd == CMD_STORE) && !len_bad && commit) ||
                ((it_cmd == CMD_READ) && !idx_bad));
    len_we   = (it_cmd == CMD_STORE);
    len_addr = (it_cmd == CMD_STORE) ? head : slot_rd;

    // result fields settled in the execute cycle; a read's stored length and byte come from the RAMs afterwards
    res_exec = '0;
    res_exec.frame_count = COUNT_OUT_W'(held);
    if (it_cmd == CMD_STORE) begin
      if (len_bad) begin
        res_exec.status = STATUS_BAD_LEN;
      end else begin
        res_exec.frame_count = COUNT_OUT_W'(held_store);
        res_exec.frame_done  = commit;
        res_exec.echo_valid  = loopback;
        res_exec.echo_byte   = loopback ? it_data : '0;
      end
    end else if (idx_bad) begin
      res_exec.status = STATUS_RANGE;
    end
  end

  frs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_byte_ram (
    .clk   (clk),
    .en    (byte_en),
    .we    (byte_we),
    .addr  (byte_addr),
    .wdata (it_data),
    .rdata (byte_rdata)
  );

  frs_ram #(.WIDTH(LEN_W), .DEPTH(RING_SLOTS)) u_len_ram (
    .clk   (clk),
    .en    (len_en),
    .we    (len_we),
    .addr  (len_addr),
    .wdata (it_len),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      head_base <= '0;
      held      <= '0;
      woff      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            it_cmd  <= command;
            it_data <= data_byte;
            it_len  <= frame_length;
            it_idx  <= frame_index;
            it_off  <= byte_offset;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res     <= res_exec;
          use_mem <= 1'b0;
          if (it_cmd == CMD_STORE) begin
            state <= ST_DONE;
            if (!len_bad) begin
              held <= held_store;
              if (commit) begin
                woff      <= '0;
                head      <= head_wrap ? '0 : head + SLOT_W'(1);
                head_base <= head_wrap ? '0 : head_base + ADDR_W'(MAX_FRAME_BYTES);
              end else begin
                woff <= woff + WOFF_W'(1);
              end
            end
          end else if (idx_bad) begin
            state <= ST_DONE;
          end else begin
            slot_reg <= slot_rd;
            state    <= ST_LEN_CHK;
          end
        end
        ST_LEN_CHK: begin
          if (off_bad) begin
            res.status <= STATUS_RANGE;
          end else begin
            res.stored_length <= len_rdata;
            use_mem           <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res_out = res;
    if (use_mem) begin
      res_out.read_byte = byte_rdata;
    end
  end

  assign req_stall = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

@@ rtl/core/frame_ring_store_drop_oldest_top.sv @@
// Top level of the overwrite-oldest frame ring store: config register,
// output register. Depends on frs_pkg and frs_ctrl (which holds the RAMs).
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+---------------------------
//  req     | command data_byte frame_length       | req_valid / req_stall
//          | frame_index byte_offset              |
//  rsp     | status read_byte stored_length       | rsp_valid / rsp_stall
//          | frame_count frame_done echo_*        |
//  cfg     | loopback_enable                      | cfg_valid / cfg_ready
//
// Store transaction, from accept to rsp_valid: latch, RAM write, result
// hand-off. Read transaction: latch, length RAM read, byte RAM read,
// hand-off; both RAM reads are skipped when the index is out of range. One
// transaction in flight; the byte RAM and length RAM are single ported
// and each touched at most once per transaction.
// Reset (rst, synchronous) clears state, pointers, counts, loopback and
// rsp_valid; the RAMs are not cleared, reads can only reach committed bytes.
// rsp_stall holds the output register; the next request is taken once the
// previous result has moved into it.
module frame_ring_store_drop_oldest_top (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          command,
  input  logic [frs_pkg::DATA_W-1:0]    data_byte,
  input  logic [frs_pkg::LEN_W-1:0]     frame_length,
  input  logic [frs_pkg::IDX_W-1:0]     frame_index,
  input  logic [frs_pkg::OFF_W-1:0]     byte_offset,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [frs_pkg::STATUS_W-1:0]  status,
  output logic [frs_pkg::DATA_W-1:0]    read_byte,
  output logic [frs_pkg::LEN_W-1:0]     stored_length,
  output logic [frs_pkg::COUNT_OUT_W-1:0] frame_count,
  output logic                          frame_done,
  output logic                          echo_valid,
  output logic [frs_pkg::DATA_W-1:0]    echo_byte,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          loopback_enable
);
  import frs_pkg::*;

  logic  loopback;
  logic  res_valid;
  logic  res_ready;
  rsp_t  res;
  rsp_t  rsp;

  // loopback register, always ready; the sender must write it between transactions, the block does not check this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      loopback <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      loopback <= loopback_enable;
    end
  end

  frs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .command      (command),
    .data_byte    (data_byte),
    .frame_length (frame_length),
    .frame_index  (frame_index),
    .byte_offset  (byte_offset),
    .loopback     (loopback),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_out      (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  assign status        = rsp.status;
  assign read_byte     = rsp.read_byte;
  assign stored_length = rsp.stored_length;
  assign frame_count   = rsp.frame_count;
  assign frame_done    = rsp.frame_done;
  assign echo_valid    = rsp.echo_valid;
  assign echo_byte     = rsp.echo_byte;

endmodule

@@ rtl/core/frs_checker.sv @@
// frs_checker: port-level assertions on the frame ring store response.
// Depends on frs_pkg; bound to frame_ring_store_drop_oldest_top below.
module frs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic [frs_pkg::STATUS_W-1:0]    status,
  input logic [frs_pkg::DATA_W-1:0]      read_byte,
  input logic [frs_pkg::LEN_W-1:0]       stored_length,
  input logic [frs_pkg::COUNT_OUT_W-1:0] frame_count,
  input logic                            frame_done,
  input logic                            echo_valid,
  input logic [frs_pkg::DATA_W-1:0]      echo_byte
);
  import frs_pkg::*;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> frame_count <= COUNT_OUT_W'(RING_SLOTS))
    else $error("frame_count above ring size");

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && frame_done |-> status == STATUS_OK && stored_length == '0)
    else $error("commit with bad status or read length");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |->
      read_byte == '0 && stored_length == '0 && !frame_done && !echo_valid)
    else $error("failed transaction carries data");

  a_echo_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !echo_valid |-> echo_byte == '0)
    else $error("echo byte without echo");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
      $stable(read_byte) && $stable(frame_count))
    else $error("stalled response changed");

endmodule

bind frame_ring_store_drop_oldest_top frs_checker u_frs_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .status        (status),
  .read_byte     (read_byte),
  .stored_length (stored_length),
  .frame_count   (frame_count),
  .frame_done    (frame_done),
  .echo_valid    (echo_valid),
  .echo_byte     (echo_byte)
);
